FILE: rtl/page_framebuffer_line_drawer_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the paged framebuffer line drawer
// Concurrent checks sampled on the rising clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef PAGE_FRAMEBUFFER_LINE_DRAWER_DEFINES_SVH
`define PAGE_FRAMEBUFFER_LINE_DRAWER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PFLD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pfld check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define PFLD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pfld check failed in the next cycle");

`endif

FILE: rtl/pfld_pkg.sv
// ----------------------------------------------------------------------------
// pfld_pkg
// Shared types and codes of the paged framebuffer line drawer.
// ----------------------------------------------------------------------------
package pfld_pkg;

	localparam int PAGE_ROWS = 8;

	localparam logic [1:0] CMD_DRAW  = 2'd0;
	localparam logic [1:0] CMD_CLEAR = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	localparam logic REG_DISP_WIDTH  = 1'b0;
	localparam logic REG_DISP_HEIGHT = 1'b1;

	typedef logic signed [8:0] coord_t;

	typedef struct packed {
		logic load;
		logic step;
	} walk_ctrl_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		logic   last;
	} walk_stat_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_CLEAR,
		ST_DRAW_RD,
		ST_DRAW_WR,
		ST_READ,
		ST_DONE
	} state_t;

endpackage

FILE: rtl/page_framebuffer_line_drawer.sv
// ----------------------------------------------------------------------------
// page_framebuffer_line_drawer
// Paged monochrome framebuffer with a Bresenham line drawer, clear and read.
//
//   Channel   Handshake               Payload
//   command   cmd_valid / cmd_stall   cmd, start_x, start_y, end_x, end_y,
//                                     pixel_on, byte_index
//   response  rsp_valid / rsp_stall   read_data, index_valid
//   config    cfg_we                  cfg_index, cfg_wdata
//
// A draw visits max(|dx|, |dy|) + 1 points of the walk, with a read-modify-write on
// the frame store for each. A clear writes width times pages store bytes, one per cycle.
// One command is at work at a time.
// After reset a clearing pass over all MAX_WIDTH * MAX_PAGES bytes runs first.
// A stalled response holds the block before it returns to idle.
// ----------------------------------------------------------------------------
module page_framebuffer_line_drawer #(
	parameter int MAX_WIDTH = 128,
	parameter int MAX_PAGES = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  logic [1:0]        cmd,
	input  logic signed [8:0] start_x,
	input  logic signed [8:0] start_y,
	input  logic signed [8:0] end_x,
	input  logic signed [8:0] end_y,
	input  logic              pixel_on,
	input  logic [9:0]        byte_index,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output logic [7:0]        read_data,
	output logic              index_valid,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [7:0]        cfg_wdata
);
	import pfld_pkg::*;

	localparam int DEPTH = MAX_WIDTH * MAX_PAGES;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = AW + 1;

	state_t         state_q, state_d;
	logic [7:0]     disp_width_q;
	logic [6:0]     disp_height_q;
	logic [CW-1:0]  cnt_q, limit_q;
	logic           rsp_valid_q;
	logic           pixel_on_q;
	logic           act_s1;
	logic [AW-1:0]  addr_s1;
	logic [2:0]     bit_s1;
	logic [7:0]     res_data_q;
	logic           res_ok_q;
	logic [7:0]     read_data_q;
	logic           index_valid_q;

	logic [7:0]     w_eff;
	logic [3:0]     p_eff;
	logic [11:0]    area;
	logic           cmd_acc, slot_free, pix_act, rd_ok;
	logic [AW-1:0]  pix_addr;
	logic [7:0]     mask;
	walk_ctrl_t     wctl;
	walk_stat_t     wstat;
	logic           mem_we, mem_re;
	logic [AW-1:0]  mem_waddr, mem_raddr;
	logic [7:0]     mem_wdata, mem_rdata;

	assign w_eff = ({1'b0, disp_width_q} > 9'(MAX_WIDTH)) ? 8'(MAX_WIDTH) : disp_width_q;
	assign p_eff = ({2'b00, disp_height_q[6:3]} > 6'(MAX_PAGES)) ? 4'(MAX_PAGES)
		: disp_height_q[6:3];
	assign area  = 12'(w_eff) * 12'(p_eff);
	assign rd_ok = {2'b00, byte_index} < area;

	assign cmd_stall = (state_q != ST_IDLE);
	assign cmd_acc   = cmd_valid && !cmd_stall;
	assign slot_free = !rsp_valid_q || !rsp_stall;

	assign pix_act  = !wstat.x[8] && ({1'b0, wstat.x[7:0]} < {1'b0, w_eff}) &&
		!wstat.y[8] && (wstat.y[7:3] < {1'b0, p_eff});
	assign pix_addr = AW'(AW'(wstat.y[7:3]) * AW'(w_eff) + AW'(wstat.x[7:0]));
	assign mask     = 8'(1) << bit_s1;

	pfld_walker u_walker (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (wctl),
		.x0     (start_x),
		.y0     (start_y),
		.x1     (end_x),
		.y1     (end_y),
		.stat   (wstat)
	);

	pfld_ram #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = cnt_q[AW-1:0];
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = pix_addr;
		wctl      = '0;
		case (state_q)
			ST_INIT: begin
				mem_we = 1'b1;
				if (cnt_q == CW'(DEPTH - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (cmd_acc) begin
					case (cmd)
						CMD_DRAW: begin
							wctl.load = 1'b1;
							state_d   = ST_DRAW_RD;
						end
						CMD_CLEAR: begin
							state_d = (area == '0) ? ST_DONE : ST_CLEAR;
						end
						CMD_READ: begin
							mem_re    = 1'b1;
							mem_raddr = AW'(byte_index);
							state_d   = ST_READ;
						end
						default: begin
							state_d = ST_DONE;
						end
					endcase
				end
			end
			ST_CLEAR: begin
				mem_we = 1'b1;
				if (cnt_q == limit_q - CW'(1)) begin
					state_d = ST_DONE;
				end
			end
			ST_DRAW_RD: begin
				mem_re  = pix_act;
				state_d = ST_DRAW_WR;
			end
			ST_DRAW_WR: begin
				mem_we    = act_s1;
				mem_waddr = addr_s1;
				mem_wdata = pixel_on_q ? (mem_rdata | mask) : (mem_rdata & ~mask);
				if (wstat.last) begin
					state_d = ST_DONE;
				end else begin
					wctl.step = 1'b1;
					state_d   = ST_DRAW_RD;
				end
			end
			ST_READ: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disp_width_q  <= 8'd128;
			disp_height_q <= 7'd64;
			cnt_q         <= '0;
			limit_q       <= '0;
			rsp_valid_q   <= 1'b0;
		end else begin
			if (cfg_we && cfg_index == REG_DISP_WIDTH) begin
				disp_width_q <= cfg_wdata;
			end
			if (cfg_we && cfg_index == REG_DISP_HEIGHT) begin
				disp_height_q <= cfg_wdata[6:0];
			end
			if (state_q == ST_INIT || state_q == ST_CLEAR) begin
				cnt_q <= cnt_q + CW'(1);
			end else begin
				cnt_q <= '0;
			end
			if (cmd_acc) begin
				limit_q <= CW'(area);
			end
			if (state_q == ST_DONE && slot_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			pixel_on_q <= pixel_on;
			res_data_q <= '0;
			res_ok_q   <= (cmd == CMD_READ) && rd_ok;
		end
		if (state_q == ST_DRAW_RD) begin
			act_s1  <= pix_act;
			addr_s1 <= pix_addr;
			bit_s1  <= wstat.y[2:0];
		end
		if (state_q == ST_READ) begin
			res_data_q <= res_ok_q ? mem_rdata : 8'd0;
		end
		if (state_q == ST_DONE && slot_free) begin
			read_data_q   <= res_data_q;
			index_valid_q <= res_ok_q;
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign read_data   = read_data_q;
	assign index_valid = index_valid_q;

endmodule

FILE: rtl/pfld_ram.sv
// ----------------------------------------------------------------------------
// pfld_ram
// Frame store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pfld_ram #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/pfld_walker.sv
// ----------------------------------------------------------------------------
// pfld_walker
// All-octant integer Bresenham stepper: one point per step request.
// ----------------------------------------------------------------------------
module pfld_walker (
	input  logic                clk,
	input  logic                arst_n,
	input  pfld_pkg::walk_ctrl_t ctrl,
	input  pfld_pkg::coord_t    x0,
	input  pfld_pkg::coord_t    y0,
	input  pfld_pkg::coord_t    x1,
	input  pfld_pkg::coord_t    y1,
	output pfld_pkg::walk_stat_t stat
);
	import pfld_pkg::*;

	coord_t              x_q, y_q, x1_q, y1_q;
	logic signed [11:0]  dx_q, dy_q, err_q;
	logic                sx_q, sy_q;

	logic signed [9:0]   diff_x, diff_y;
	logic signed [11:0]  adx, ady, err_n;
	logic signed [12:0]  e2;
	logic                step_x, step_y;

	always_comb begin
		diff_x = 10'(x1) - 10'(x0);
		diff_y = 10'(y1) - 10'(y0);
		adx    = diff_x[9] ? -12'(diff_x) : 12'(diff_x);
		ady    = diff_y[9] ? -12'(diff_y) : 12'(diff_y);
		e2     = {err_q, 1'b0};
		step_x = e2 >= 13'(dy_q);
		step_y = e2 <= 13'(dx_q);
		err_n  = err_q;
		if (step_x) begin
			err_n = err_n + dy_q;
		end
		if (step_y) begin
			err_n = err_n + dx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q   <= '0;
			y_q   <= '0;
			x1_q  <= '0;
			y1_q  <= '0;
			dx_q  <= '0;
			dy_q  <= '0;
			err_q <= '0;
			sx_q  <= 1'b0;
			sy_q  <= 1'b0;
		end else if (ctrl.load) begin
			x_q   <= x0;
			y_q   <= y0;
			x1_q  <= x1;
			y1_q  <= y1;
			dx_q  <= adx;
			dy_q  <= -ady;
			err_q <= adx - ady;
			sx_q  <= x0 < x1;
			sy_q  <= y0 < y1;
		end else if (ctrl.step) begin
			err_q <= err_n;
			if (step_x) begin
				x_q <= sx_q ? x_q + 9'sd1 : x_q - 9'sd1;
			end
			if (step_y) begin
				y_q <= sy_q ? y_q + 9'sd1 : y_q - 9'sd1;
			end
		end
	end

	assign stat.x    = x_q;
	assign stat.y    = y_q;
	assign stat.last = (x_q == x1_q) && (y_q == y1_q);

endmodule

FILE: rtl/pfld_checker.sv
// ----------------------------------------------------------------------------
// pfld_checker
// Port-level checks of the paged framebuffer line drawer, bound to the top.
// ----------------------------------------------------------------------------
`include "page_framebuffer_line_drawer_defines.svh"

module pfld_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       cmd_valid,
	input logic       cmd_stall,
	input logic       rsp_valid,
	input logic       rsp_stall,
	input logic [7:0] read_data,
	input logic       index_valid
);

	logic rsp_held;

	assign rsp_held = rsp_valid && rsp_stall;

	// A stalled response stays valid.
	`PFLD_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_held, rsp_valid)

	// A stalled response keeps its payload.
	`PFLD_ASSERT_NEXT(a_rsp_data, clk, arst_n, rsp_held, $stable({read_data, index_valid}))

	// A response without a valid index carries a zero byte.
	`PFLD_ASSERT_SAME(a_rsp_zero, clk, arst_n, rsp_valid && !index_valid, read_data == 8'd0)

	// Every accepted request keeps the block busy in the cycle after it.
	`PFLD_ASSERT_NEXT(a_req_busy, clk, arst_n, cmd_valid && !cmd_stall, cmd_stall)

endmodule

bind page_framebuffer_line_drawer pfld_checker u_pfld_checker (.*);
